FILE: hw/rtl/contiguous_page_allocator_compacting_core_macros.svh
// assertion macros used by the page allocator rtl (cpa_ctrl)
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_COMPACTING_CORE_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_COMPACTING_CORE_MACROS_SVH

// condition that holds at every clock edge outside reset
`define CPA_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("cpa check failed");

// same-cycle implication
`define CPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpa implication failed");

`endif

FILE: hw/rtl/cpa_pkg.sv
// types, codes and defaults for the contiguous page allocator
`default_nettype none
package cpa_pkg;

  localparam int MAX_PAGES_DEF  = 64;
  localparam int OWNER_BITS_DEF = 16;
  localparam logic [6:0] CFG_RESET = 7'd32;

  localparam logic KIND_MOVE   = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_XLATE = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_NO_OWNER   = 2'd2,
    ST_BAD_OFFSET = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_MOVES,
    S_SORT,
    S_FREE,
    S_COUNT,
    S_ANSWER
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] owner_id;
    logic [6:0]  page_count;
    logic [5:0]  page_offset;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] move_from;
    logic [5:0] move_to;
    logic [1:0] status;
    logic [5:0] phys_page;
    logic       last;
  } res_t;

  typedef struct packed {
    logic shift;
    logic sort;
    logic phase;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cpa_cell.sv
// one page entry of the table: rotates toward page 0 or swaps with a neighbor
`default_nettype none
module cpa_cell
  import cpa_pkg::*;
#(
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic                  parity,
  input  wire logic                  self_in_range,
  input  wire logic                  up_in_range,
  input  wire logic                  up_used,
  input  wire logic [OWNER_BITS-1:0] up_owner,
  input  wire logic                  dn_used,
  output logic                       used,
  output logic [OWNER_BITS-1:0]      owner
);

  logic                  used_next;
  logic [OWNER_BITS-1:0] owner_next;

  // shift takes the upper neighbor; sort does one odd-even step
  always_comb begin
    used_next  = used;
    owner_next = owner;
    if (ctrl.shift) begin
      used_next  = up_used;
      owner_next = up_owner;
    end else if (ctrl.sort) begin
      if (parity == ctrl.phase) begin
        // lower member of the pair pulls a used page down
        if (up_in_range && !used && up_used) begin
          used_next  = 1'b1;
          owner_next = up_owner;
        end
      end else begin
        // upper member of the pair gives its page away
        if (self_in_range && !dn_used && used) begin
          used_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      used <= used_next;
    end
    owner <= owner_next;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cpa_ctrl.sv
// request sequencer: scan passes over the rotating table and the output register
`default_nettype none
`include "contiguous_page_allocator_compacting_core_macros.svh"
module cpa_ctrl
  import cpa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF,
  localparam int IW = $clog2(MAX_PAGES),
  localparam int CW = $clog2(MAX_PAGES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CW-1:0]         n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire req_t                  in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output res_t                       out_item,
  input  wire logic                  head_used,
  input  wire logic [OWNER_BITS-1:0] head_owner,
  output logic                       fb_used,
  output logic [OWNER_BITS-1:0]      fb_owner,
  output cell_ctrl_t                 cell_ctrl
);

  state_e        state, state_next;
  req_t          req, req_next;
  logic [IW-1:0] idx, idx_next;
  logic          second, second_next;
  logic [CW-1:0] run, run_next;
  logic [IW-1:0] start, start_next;
  logic          found, found_next;
  logic [IW-1:0] dst, dst_next;
  logic [CW-1:0] held, held_next;
  logic [IW-1:0] first, first_next;
  logic          out_valid_next;
  res_t          out_item_next;
  status_e       ans_status, ans_status_next;
  logic [5:0]    ans_phys, ans_phys_next;

  logic                  in_range;
  logic                  last_idx;
  logic [IW-1:0]         idx_inc;
  logic                  out_free;
  logic [OWNER_BITS-1:0] req_owner;
  logic                  head_match;
  logic [CW-1:0]         run_inc;
  logic                  hit;
  logic                  window;
  logic                  emit;
  logic [CW-1:0]         held_now;
  logic [IW-1:0]         first_now;
  res_t                  move_res;

  assign req_owner  = OWNER_BITS'(req.owner_id);
  assign in_range   = CW'(idx) < n;
  assign last_idx   = (idx == IW'(MAX_PAGES - 1));
  assign idx_inc    = last_idx ? '0 : IW'(idx + 1'b1);
  assign out_free   = !out_valid || out_ready;
  assign head_match = head_used && in_range && (head_owner == req_owner);
  assign run_inc    = CW'(run + 1'b1);
  assign hit        = !found && in_range && !head_used &&
                      (8'(run_inc) >= 8'(req.page_count));
  assign window     = (idx >= start) &&
                      (8'(idx) < (8'(start) + 8'(req.page_count)));
  assign emit       = head_used && in_range && (idx != dst);
  assign held_now   = head_match ? CW'(held + 1'b1) : held;
  assign first_now  = (head_match && (held == '0)) ? idx : first;

  always_comb begin
    move_res           = '0;
    move_res.kind      = KIND_MOVE;
    move_res.move_from = 6'(idx);
    move_res.move_to   = 6'(dst);
  end

  // next state, pass bookkeeping and table feedback
  always_comb begin
    state_next      = state;
    req_next        = req;
    idx_next        = idx;
    second_next     = second;
    run_next        = run;
    start_next      = start;
    found_next      = found;
    dst_next        = dst;
    held_next       = held;
    first_next      = first;
    ans_status_next = ans_status;
    ans_phys_next   = ans_phys;
    out_valid_next  = out_valid && !out_ready;
    out_item_next   = out_item;
    fb_used         = head_used;
    fb_owner        = head_owner;
    cell_ctrl       = '0;
    in_ready        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_next    = in_item;
          idx_next    = '0;
          run_next    = '0;
          found_next  = 1'b0;
          second_next = 1'b0;
          held_next   = '0;
          first_next  = '0;
          case (in_item.action)
            ACT_ALLOC: begin
              if (in_item.page_count == '0) begin
                ans_status_next = ST_NO_ROOM;
                ans_phys_next   = '0;
                state_next      = S_ANSWER;
              end else begin
                state_next = S_SCAN;
              end
            end
            ACT_FREE:  state_next = S_FREE;
            ACT_XLATE: state_next = S_COUNT;
            default: begin
              ans_status_next = ST_OK;
              ans_phys_next   = '0;
              state_next      = S_ANSWER;
            end
          endcase
        end
      end
      S_SCAN: begin
        // first-fit run search as pages pass the head
        cell_ctrl.shift = 1'b1;
        idx_next        = idx_inc;
        if (!found && in_range) begin
          if (!head_used) begin
            run_next = run_inc;
            if (run == '0) begin
              start_next = idx;
            end
          end else begin
            run_next = '0;
          end
        end
        if (hit) begin
          found_next = 1'b1;
        end
        if (last_idx) begin
          if (found || hit) begin
            state_next = S_WRITE;
          end else if (!second) begin
            dst_next   = '0;
            state_next = S_MOVES;
          end else begin
            ans_status_next = ST_NO_ROOM;
            ans_phys_next   = '0;
            state_next      = S_ANSWER;
          end
        end
      end
      S_WRITE: begin
        // claim the run found by the scan
        cell_ctrl.shift = 1'b1;
        idx_next        = idx_inc;
        if (window) begin
          fb_used  = 1'b1;
          fb_owner = req_owner;
        end
        if (last_idx) begin
          ans_status_next = ST_OK;
          ans_phys_next   = 6'(start);
          state_next      = S_ANSWER;
        end
      end
      S_MOVES: begin
        // report each page that compaction will move, stall on a full output
        if (!(emit && !out_free)) begin
          cell_ctrl.shift = 1'b1;
          idx_next        = idx_inc;
          if (emit) begin
            out_valid_next = 1'b1;
            out_item_next  = move_res;
          end
          if (head_used && in_range) begin
            dst_next = IW'(dst + 1'b1);
          end
          if (last_idx) begin
            state_next = S_SORT;
          end
        end
      end
      S_SORT: begin
        // odd-even steps slide used pages down in order
        cell_ctrl.sort  = 1'b1;
        cell_ctrl.phase = idx[0];
        idx_next        = idx_inc;
        if (last_idx) begin
          second_next = 1'b1;
          run_next    = '0;
          found_next  = 1'b0;
          state_next  = S_SCAN;
        end
      end
      S_FREE: begin
        cell_ctrl.shift = 1'b1;
        idx_next        = idx_inc;
        if (head_match) begin
          fb_used    = 1'b0;
          found_next = 1'b1;
        end
        if (last_idx) begin
          ans_status_next = (found || head_match) ? ST_OK : ST_NO_OWNER;
          ans_phys_next   = '0;
          state_next      = S_ANSWER;
        end
      end
      S_COUNT: begin
        cell_ctrl.shift = 1'b1;
        idx_next        = idx_inc;
        held_next       = held_now;
        first_next      = first_now;
        if (last_idx) begin
          ans_phys_next = '0;
          if (held_now == '0) begin
            ans_status_next = ST_NO_OWNER;
          end else if ({1'b0, req.page_offset} >= 7'(held_now)) begin
            ans_status_next = ST_BAD_OFFSET;
          end else begin
            ans_status_next = ST_OK;
            ans_phys_next   = 6'(first_now) + req.page_offset;
          end
          state_next = S_ANSWER;
        end
      end
      S_ANSWER: begin
        if (out_free) begin
          out_valid_next          = 1'b1;
          out_item_next           = '0;
          out_item_next.kind      = KIND_ANSWER;
          out_item_next.status    = ans_status;
          out_item_next.phys_page = ans_phys;
          out_item_next.last      = 1'b1;
          state_next              = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // pass registers and payload
  always_ff @(posedge clk) begin
    req        <= req_next;
    idx        <= idx_next;
    second     <= second_next;
    run        <= run_next;
    start      <= start_next;
    found      <= found_next;
    dst        <= dst_next;
    held       <= held_next;
    first      <= first_next;
    ans_status <= ans_status_next;
    ans_phys   <= ans_phys_next;
    out_item   <= out_item_next;
  end

  `CPA_ASSERT(a_dst_behind, (state != S_MOVES) || (dst <= idx))
  `CPA_ASSERT_IMP(a_write_found, state == S_WRITE, found)
  `CPA_ASSERT(a_held_bound, (state != S_COUNT) || (held <= n))

endmodule
`default_nettype wire

FILE: hw/rtl/contiguous_page_allocator_compacting_core.sv
// Page allocator: one item is worked on at a time over a rotating ring of page cells.
// Each shifting pass brings one page of the ring to the head per cycle, pausing while a move item waits.
// Free and translate answer after one pass; allocate with room scans and then writes the run.
// Allocate with compaction adds a move pass, a sort pass and a second scan, and may stall on move items.
// Synchronous reset marks every page free and sets pages_in_use to 32; no clearing pass.
`default_nettype none
module contiguous_page_allocator_compacting_core
  import cpa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [6:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire req_t       in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output res_t            out_item
);

  localparam int CW = $clog2(MAX_PAGES + 1);

  logic [6:0]            pages_in_use;
  logic [CW-1:0]         n;
  logic                  used  [MAX_PAGES];
  logic [OWNER_BITS-1:0] owner [MAX_PAGES];
  logic                  fb_used;
  logic [OWNER_BITS-1:0] fb_owner;
  cell_ctrl_t            cell_ctrl;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      pages_in_use <= cfg_wr_data;
    end
  end

  // managed page count, saturated to 1..MAX_PAGES
  always_comb begin
    if (pages_in_use == '0) begin
      n = CW'(1);
    end else if (pages_in_use > 7'(MAX_PAGES)) begin
      n = CW'(MAX_PAGES);
    end else begin
      n = CW'(pages_in_use);
    end
  end

  // ring of page cells, page 0 at the head
  for (genvar j = 0; j < MAX_PAGES; j++) begin : g_cell
    logic                  up_used;
    logic [OWNER_BITS-1:0] up_owner;
    logic                  dn_used;
    logic                  up_in_range;

    if (j == MAX_PAGES - 1) begin : g_top
      assign up_used     = fb_used;
      assign up_owner    = fb_owner;
      assign up_in_range = 1'b0;
    end else begin : g_mid
      assign up_used     = used[j+1];
      assign up_owner    = owner[j+1];
      assign up_in_range = CW'(j + 1) < n;
    end

    if (j == 0) begin : g_bot
      assign dn_used = 1'b1;
    end else begin : g_up
      assign dn_used = used[j-1];
    end

    cpa_cell #(
      .OWNER_BITS(OWNER_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cell_ctrl),
      .parity       (1'(j % 2)),
      .self_in_range(CW'(j) < n),
      .up_in_range  (up_in_range),
      .up_used      (up_used),
      .up_owner     (up_owner),
      .dn_used      (dn_used),
      .used         (used[j]),
      .owner        (owner[j])
    );
  end

  cpa_ctrl #(
    .MAX_PAGES (MAX_PAGES),
    .OWNER_BITS(OWNER_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .head_used (used[0]),
    .head_owner(owner[0]),
    .fb_used   (fb_used),
    .fb_owner  (fb_owner),
    .cell_ctrl (cell_ctrl)
  );

endmodule
`default_nettype wire

FILE: sim/contiguous_page_allocator_compacting_core_tb.sv
// testbench for the compacting page allocator: directed and random requests checked against a predictor
`default_nettype none
module contiguous_page_allocator_compacting_core_tb;
  import cpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  req_t       in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  res_t       out_item;

  contiguous_page_allocator_compacting_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [6:0]  pages_reg;
  logic        used_tbl [MAX_PAGES_DEF];
  logic [15:0] owner_tbl [MAX_PAGES_DEF];
  res_t        expected_q [$];
  int          errors = 0;
  int          sent = 0;
  int          answers = 0;
  int          moves = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic int managed();
    if (pages_reg == 0) return 1;
    if (pages_reg > MAX_PAGES_DEF) return MAX_PAGES_DEF;
    return pages_reg;
  endfunction

  function automatic res_t answer(status_e st, logic [5:0] phys);
    res_t r;
    r = '0;
    r.kind = KIND_ANSWER;
    r.status = st;
    r.phys_page = phys;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int first_fit(int n, int need);
    int run;
    int start;
    run = 0;
    start = 0;
    for (int i = 0; i < n; i++) begin
      if (!used_tbl[i]) begin
        if (run == 0) start = i;
        run++;
        if (run >= need) return start;
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  // work out the results of one request and update the page table
  function automatic void predict_request(req_t rq);
    int n;
    int start;
    int dst;
    int held;
    int first;
    bit found;
    res_t mv;
    n = managed();
    case (action_e'(rq.action))
      ACT_ALLOC: begin
        if (rq.page_count == 0) begin
          expected_q.push_back(answer(ST_NO_ROOM, 0));
        end else begin
          start = first_fit(n, rq.page_count);
          if (start < 0) begin
            // slide occupied pages down, lowest first
            dst = 0;
            for (int s = 0; s < n; s++) begin
              if (used_tbl[s]) begin
                if (s != dst) begin
                  used_tbl[dst] = 1'b1;
                  owner_tbl[dst] = owner_tbl[s];
                  used_tbl[s] = 1'b0;
                  mv = '0;
                  mv.kind = KIND_MOVE;
                  mv.move_from = s[5:0];
                  mv.move_to = dst[5:0];
                  expected_q.push_back(mv);
                end
                dst++;
              end
            end
            start = first_fit(n, rq.page_count);
          end
          if (start < 0) begin
            expected_q.push_back(answer(ST_NO_ROOM, 0));
          end else begin
            for (int i = 0; i < rq.page_count; i++) begin
              if (start + i < MAX_PAGES_DEF) begin
                used_tbl[start + i] = 1'b1;
                owner_tbl[start + i] = rq.owner_id;
              end
            end
            expected_q.push_back(answer(ST_OK, start[5:0]));
          end
        end
      end
      ACT_FREE: begin
        found = 0;
        for (int i = 0; i < n; i++) begin
          if (used_tbl[i] && owner_tbl[i] == rq.owner_id) begin
            used_tbl[i] = 1'b0;
            found = 1;
          end
        end
        expected_q.push_back(answer(found ? ST_OK : ST_NO_OWNER, 0));
      end
      ACT_XLATE: begin
        held = 0;
        first = 0;
        for (int i = 0; i < n; i++) begin
          if (used_tbl[i] && owner_tbl[i] == rq.owner_id) begin
            if (held == 0) first = i;
            held++;
          end
        end
        if (held == 0) expected_q.push_back(answer(ST_NO_OWNER, 0));
        else if (rq.page_offset >= held) expected_q.push_back(answer(ST_BAD_OFFSET, 0));
        else expected_q.push_back(answer(ST_OK, 6'(first + rq.page_offset)));
      end
      default: expected_q.push_back(answer(ST_OK, 0));
    endcase
  endfunction

  // send one item, with random idle cycles before it
  task automatic send_item(req_t rq);
    // step past the edge where the previous item dropped valid
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_item <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(rq);
    sent++;
    in_valid <= 1'b0;
  endtask

  task automatic send_fields(action_e act, logic [15:0] own, logic [6:0] cnt,
                             logic [5:0] off);
    req_t rq;
    rq.action = act;
    rq.owner_id = own;
    rq.page_count = cnt;
    rq.page_offset = off;
    send_item(rq);
  endtask

  // wait until all results are in, then let the block settle
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (5 * MAX_PAGES_DEF + 10) @(posedge clk);
  endtask

  task automatic write_pages(logic [6:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pages_reg = v;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, out_item);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_item !== e) begin
          $display("%0t mismatch: expected %p, actual %p", $time, e, out_item);
          errors++;
        end
        if (out_item.kind == KIND_MOVE) moves++;
        else answers++;
      end
    end
  end

  task automatic test_directed();
    send_fields(ACT_ALLOC, 16'h0000, 7'd0, 6'd0);
    send_fields(ACT_FREE, 16'h1234, 7'd1, 6'd0);
    send_fields(ACT_XLATE, 16'h1234, 7'd1, 6'd0);
    send_fields(ACT_ALLOC, 16'hFFFF, 7'd1, 6'd63);
    send_fields(ACT_ALLOC, 16'h0001, 7'd4, 6'd0);
    send_fields(ACT_ALLOC, 16'hFFFF, 7'd3, 6'd0);
    send_fields(ACT_XLATE, 16'hFFFF, 7'd0, 6'd3);
    send_fields(ACT_XLATE, 16'hFFFF, 7'd0, 6'd4);
    send_fields(ACT_XLATE, 16'h0001, 7'd0, 6'd63);
    send_fields(ACT_NOP, 16'hAAAA, 7'h7F, 6'h3F);
    send_fields(ACT_FREE, 16'h0001, 7'd0, 6'd0);
    // hole in the middle forces compaction
    send_fields(ACT_ALLOC, 16'h0002, 7'd26, 6'd0);
    send_fields(ACT_FREE, 16'h0002, 7'd0, 6'd0);
    send_fields(ACT_ALLOC, 16'h0003, 7'd30, 6'd0);
    send_fields(ACT_ALLOC, 16'h0004, 7'd40, 6'd0);
    send_fields(ACT_ALLOC, 16'h0005, 7'h7F, 6'd0);
    send_fields(ACT_FREE, 16'hFFFF, 7'd0, 6'd0);
    send_fields(ACT_FREE, 16'h0003, 7'd0, 6'd0);
  endtask

  task automatic test_config_extremes();
    write_pages(7'd64);
    send_fields(ACT_ALLOC, 16'h5555, 7'd64, 6'd0);
    send_fields(ACT_XLATE, 16'h5555, 7'd0, 6'd63);
    send_fields(ACT_FREE, 16'h5555, 7'd0, 6'd0);
    write_pages(7'd1);
    send_fields(ACT_ALLOC, 16'h6666, 7'd1, 6'd0);
    send_fields(ACT_ALLOC, 16'h6666, 7'd1, 6'd0);
    write_pages(7'd0);
    send_fields(ACT_XLATE, 16'h6666, 7'd0, 6'd0);
    write_pages(7'd127);
    send_fields(ACT_FREE, 16'h6666, 7'd0, 6'd0);
  endtask

  // mostly allocate/free/translate over a small owner pool, some full-range noise
  task automatic test_random(int count);
    req_t rq;
    for (int i = 0; i < count; i++) begin
      rq = '0;
      rq.action = ($urandom_range(3) == 0) ? 2'($urandom_range(1, 2))
                                           : 2'($urandom_range(0, 2));
      if ($urandom_range(9) == 0) rq.action = ACT_NOP;
      rq.owner_id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      if ($urandom_range(15) == 0) rq.owner_id = 16'hFFFF;
      rq.page_count = ($urandom_range(19) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12));
      rq.page_offset = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(5));
      send_item(rq);
      if (i == count / 2) drain();
    end
  endtask

  // stimulus
  initial begin
    pages_reg = CFG_RESET;
    for (int i = 0; i < MAX_PAGES_DEF; i++) begin
      used_tbl[i] = 1'b0;
      owner_tbl[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    write_pages(7'd32);
    test_random(60);
    send_idle_pct = 56;
    write_pages(7'd20);
    test_random(60);
    send_idle_pct = 0;
    recv_stall_pct = 56;
    write_pages(7'd48);
    test_random(60);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    write_pages(7'd64);
    test_random(50);
    drain();
    $display("covered %0d requests, %0d answers and %0d compaction moves", sent, answers,
             moves);
    $display("page counts 0, 1, 20, 32, 48, 64 and 127 with sender and receiver stalls");
    if (errors == 0) begin
      $display("[contiguous_page_allocator_compacting_core] OK");
    end else begin
      $display("[contiguous_page_allocator_compacting_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("[contiguous_page_allocator_compacting_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

FILE: contiguous_page_allocator_compacting_core.f
+incdir+hw/rtl
hw/rtl/cpa_pkg.sv
hw/rtl/cpa_cell.sv
hw/rtl/cpa_ctrl.sv
hw/rtl/contiguous_page_allocator_compacting_core.sv
sim/contiguous_page_allocator_compacting_core_tb.sv
